// File: rtl/cube_map_texel_normal_encoder_unit_defines.svh
// Assertion macros shared by the cube map texel normal encoder.
// Needs clk and rst in the including scope.
`ifndef CUBE_MAP_TEXEL_NORMAL_ENCODER_UNIT_DEFINES_SVH
`define CUBE_MAP_TEXEL_NORMAL_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CMTN_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CMTN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cmtn_pkg.sv
// Shared types, constants and the square table of the cube map normal encoder.
// No dependencies.
`timescale 1ns / 1ps

package cmtn_pkg;

  localparam int FACE_SIZE = 32;

  localparam int IDX_W   = 5;
  localparam int MAG_W   = $clog2(FACE_SIZE + 1);
  localparam int COORD_W = MAG_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int LEN2_W  = $clog2(3 * FACE_SIZE * FACE_SIZE);
  localparam int BYTE_W  = 8;
  localparam int ASQ_W   = 2 * BYTE_W;
  localparam int RHS_W   = SQ_W + ASQ_W;
  localparam int LHS_W   = ASQ_W + LEN2_W;
  localparam int LANES   = 3;
  localparam int LATENCY = 12;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  localparam logic [RHS_W-1:0]  SCALE_SQ    = RHS_W'(255 * 255);
  localparam logic [BYTE_W-1:0] FIRST_PROBE = BYTE_W'(1 << (BYTE_W - 1));

  typedef struct packed {
    logic [2:0]       face;
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
  } texel_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } texel_out_t;

  typedef struct packed {
    logic              neg;
    logic [RHS_W-1:0]  rhs;
    logic [BYTE_W-1:0] k;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  bad_face;
    logic [LEN2_W-1:0]     len2;
    logic [BYTE_W-1:0]     probe;
    lane_t [LANES-1:0]     lane;
  } search_t;

  typedef logic [ASQ_W-1:0] sq_table_t [1 << BYTE_W];

  function automatic sq_table_t build_sq_table();
    sq_table_t tbl;
    for (int i = 0; i < (1 << BYTE_W); i++) begin
      tbl[i] = ASQ_W'(i * i);
    end
    return tbl;
  endfunction

  localparam sq_table_t SQ_TABLE = build_sq_table();

endpackage

// File: rtl/cmtn_prep.sv
// Front stages: face decode, component squares and length, scaled right-hand sides.
// Depends on cmtn_pkg.
`timescale 1ns / 1ps

module cmtn_prep import cmtn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  texel_in_t texel,
  output search_t   search_head
);

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } comp_t;

  localparam logic [IDX_W-1:0]          COORD_MAX = IDX_W'(FACE_SIZE - 1);
  localparam logic signed [COORD_W-1:0] S_COORD   = COORD_W'(FACE_SIZE);

  // stage A: decoded components
  logic                 a_valid;
  logic                 a_bad;
  comp_t [LANES-1:0]    a_comp;
  // stage B: squares and squared length
  logic                 b_valid;
  logic                 b_bad;
  logic [LANES-1:0]     b_neg;
  logic [SQ_W-1:0]      b_sq [LANES];
  logic [LEN2_W-1:0]    b_len2;

  logic [IDX_W-1:0]          col_sat;
  logic [IDX_W-1:0]          row_sat;
  logic signed [COORD_W-1:0] u;
  logic signed [COORD_W-1:0] v;
  logic signed [COORD_W-1:0] c [LANES];
  logic                      bad;
  comp_t [LANES-1:0]         comp_next;
  logic [SQ_W-1:0]           sq_next [LANES];

  always_comb begin
    col_sat = (texel.column > COORD_MAX) ? COORD_MAX : texel.column;
    row_sat = (texel.row > COORD_MAX) ? COORD_MAX : texel.row;
    u = $signed(COORD_W'({col_sat, 1'b1})) - S_COORD;
    v = $signed(COORD_W'({row_sat, 1'b1})) - S_COORD;
    bad = 1'b0;
    unique case (texel.face)
      FACE_POS_X: begin
        c[0] = S_COORD;  c[1] = -v;       c[2] = -u;
      end
      FACE_NEG_X: begin
        c[0] = -S_COORD; c[1] = -v;       c[2] = u;
      end
      FACE_POS_Y: begin
        c[0] = u;        c[1] = S_COORD;  c[2] = v;
      end
      FACE_NEG_Y: begin
        c[0] = u;        c[1] = -S_COORD; c[2] = -v;
      end
      FACE_POS_Z: begin
        c[0] = u;        c[1] = -v;       c[2] = S_COORD;
      end
      FACE_NEG_Z: begin
        c[0] = -u;       c[1] = -v;       c[2] = -S_COORD;
      end
      default: begin
        c[0] = '0;       c[1] = '0;       c[2] = '0;
        bad = 1'b1;
      end
    endcase
    for (int i = 0; i < LANES; i++) begin
      comp_next[i].neg = c[i][COORD_W-1];
      comp_next[i].mag = MAG_W'(c[i][COORD_W-1] ? -c[i] : c[i]);
      sq_next[i] = SQ_W'(a_comp[i].mag) * SQ_W'(a_comp[i].mag);
    end
  end

  always_ff @(posedge clk) begin
    a_valid <= accept;
    a_bad   <= bad;
    a_comp  <= comp_next;

    b_valid <= a_valid;
    b_bad   <= a_bad;
    for (int i = 0; i < LANES; i++) begin
      b_neg[i] <= a_comp[i].neg;
      b_sq[i]  <= sq_next[i];
    end
    b_len2 <= LEN2_W'(sq_next[0]) + LEN2_W'(sq_next[1]) + LEN2_W'(sq_next[2]);

    search_head.valid    <= b_valid;
    search_head.bad_face <= b_bad;
    search_head.len2     <= b_len2;
    search_head.probe    <= FIRST_PROBE;
    for (int i = 0; i < LANES; i++) begin
      search_head.lane[i].neg <= b_neg[i];
      search_head.lane[i].rhs <= RHS_W'(b_sq[i]) * SCALE_SQ;
      search_head.lane[i].k   <= '0;
    end

    if (rst) begin
      a_valid           <= 1'b0;
      b_valid           <= 1'b0;
      search_head.valid <= 1'b0;
    end
  end

endmodule

// File: rtl/cmtn_search_stage.sv
// One bit of the byte search for all three lanes: try the probe bit, keep it if it fits.
// Depends on cmtn_pkg.
`timescale 1ns / 1ps

module cmtn_search_stage import cmtn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  search_t upstream,
  output search_t downstream
);

  search_t            stage_next;
  logic [BYTE_W-1:0]  trial [LANES];
  logic [BYTE_W-1:0]  am [LANES];
  logic [LHS_W-1:0]   lhs [LANES];
  logic [LANES-1:0]   fits;

  always_comb begin
    stage_next       = upstream;
    stage_next.probe = upstream.probe >> 1;
    for (int i = 0; i < LANES; i++) begin
      trial[i] = upstream.lane[i].k | upstream.probe;
      // |2t - 255|: odd, and the top bit of t gives the sign of 2t - 255
      am[i] = trial[i][BYTE_W-1] ? {trial[i][BYTE_W-2:0], 1'b1}
                                 : ~{trial[i][BYTE_W-2:0], 1'b0};
      lhs[i] = LHS_W'(SQ_TABLE[am[i]]) * LHS_W'(upstream.len2);
      if (trial[i][BYTE_W-1]) begin
        fits[i] = !upstream.lane[i].neg && (lhs[i] <= LHS_W'(upstream.lane[i].rhs));
      end else begin
        fits[i] = !upstream.lane[i].neg || (lhs[i] >= LHS_W'(upstream.lane[i].rhs));
      end
      if (fits[i]) begin
        stage_next.lane[i].k = trial[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    downstream <= stage_next;
    if (rst) begin
      downstream.valid <= 1'b0;
    end
  end

endmodule

// File: rtl/cube_map_texel_normal_encoder_unit.sv
// Top level of the cube map texel normal encoder: front stages, eight search stages,
// output register. Depends on cmtn_pkg, cmtn_prep, cmtn_search_stage and the defines header.
//
//   channel   signals                    width  direction
//   command   start, busy, texel         1/1/13 in/out/in
//   result    done, result               1/24   out
//
// One transaction per cycle; each result passes the front stages, the search stages and the output register.
// The eight byte-search stages each settle one bit of every result byte.
// busy stays low: the pipeline never stalls, and the receiver cannot stall it.
// Synchronous reset clears the valid bits only; no result follows reset.
`timescale 1ns / 1ps
`include "cube_map_texel_normal_encoder_unit_defines.svh"

module cube_map_texel_normal_encoder_unit import cmtn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  texel_in_t  texel,
  output logic       done,
  output texel_out_t result
);

  localparam int STAGES = BYTE_W;

  search_t chain [STAGES + 1];
  logic    accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cmtn_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .texel       (texel),
    .search_head (chain[0])
  );

  for (genvar g = 0; g < STAGES; g++) begin : g_search
    cmtn_search_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .upstream   (chain[g]),
      .downstream (chain[g + 1])
    );
  end

  // zero the bytes for a face code that names no face
  always_ff @(posedge clk) begin
    done         <= chain[STAGES].valid;
    result.red   <= chain[STAGES].bad_face ? '0 : chain[STAGES].lane[0].k;
    result.green <= chain[STAGES].bad_face ? '0 : chain[STAGES].lane[1].k;
    result.blue  <= chain[STAGES].bad_face ? '0 : chain[STAGES].lane[2].k;
    if (rst) begin
      done <= 1'b0;
    end
  end

  `CMTN_ASSERT_NEXT(a_latency, accept, ##(LATENCY - 1) done, "result missing after command")
  `CMTN_ASSERT(a_no_spurious, done, $past(accept && !rst, LATENCY), "result without command")
  `CMTN_ASSERT(a_bad_face_zero, $past(accept && !rst && texel.face > FACE_NEG_Z, LATENCY), done && result == '0, "bad face gave nonzero result")

endmodule
